[src/kpsw_pkg.sv]
// Package for the keypad stopwatch controller.
// Holds the payload types, the register index codes, the key codes and the reset values.
// Has no dependencies.
`default_nettype none

package kpsw_pkg;

  localparam int unsigned DEB_W    = 8;
  localparam int unsigned REL_W    = 8;
  localparam int unsigned PER_W    = 10;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned NDIGITS  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [DEB_W-1:0]   DEB_RESET = 8'd32;
  localparam logic [REL_W-1:0]   REL_RESET = 8'd32;
  localparam logic [PER_W-1:0]   PER_RESET = 10'd997;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  localparam logic [POS_W-1:0] KEY_START = 4'd10;
  localparam logic [POS_W-1:0] KEY_STOP  = 4'd11;
  localparam logic [POS_W-1:0] KEY_CLEAR = 4'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_RELEASE  = 2'd1,
    CFG_PERIOD   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic key_sense;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]   next_scan_position;
    logic               key_accepted;
    logic [POS_W-1:0]   accepted_key;
    logic               key_held;
    logic               running;
    logic               second_event;
    logic [DIGIT_W-1:0] digit_ones;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_thousands;
  } out_item_t;

  // key detection result of one tick
  typedef struct packed {
    logic             accepted;
    logic [POS_W-1:0] key;
    logic             held;
    logic [POS_W-1:0] next_pos;
  } key_evt_t;

endpackage

`default_nettype wire

[src/kpsw_if.sv]
// Valid/ready channel interfaces for the keypad stopwatch controller.
// Depends on kpsw_pkg for the payload types.
`default_nettype none

interface kpsw_in_if import kpsw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kpsw_out_if import kpsw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/kpsw_keypad.sv]
// Keypad scan, debounce and release detection for one tick per enable.
// Depends on kpsw_pkg.
`default_nettype none

module kpsw_keypad import kpsw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             key_sense_i,
  input  wire logic [DEB_W-1:0] debounce_ticks_i,
  input  wire logic [REL_W-1:0] release_ticks_i,
  output key_evt_t              evt_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [DEB_W-1:0] deb_q, deb_d;
  logic [POS_W-1:0] cap_q, cap_d;
  logic             ready_q, ready_d;
  logic [REL_W-1:0] rel_q, rel_d;
  logic [REL_W-1:0] rel_dec;
  logic [DEB_W-1:0] deb_dec;
  logic             pressed;
  logic             accepted;

  always_comb begin
    pressed  = ~key_sense_i;
    rel_dec  = rel_q - REL_W'(1);
    deb_dec  = deb_q - DEB_W'(1);
    pos_d    = pos_q + POS_W'(1);
    deb_d    = deb_q;
    cap_d    = cap_q;
    ready_d  = ready_q;
    rel_d    = rel_q;
    accepted = 1'b0;
    if (ready_q) begin
      if (pressed) begin
        rel_d = release_ticks_i;
      end else if (rel_dec == '0) begin
        ready_d = 1'b0;
        rel_d   = release_ticks_i;
      end else begin
        rel_d = rel_dec;
      end
    end else if (deb_q == '0) begin
      if (pressed) begin
        deb_d = debounce_ticks_i;
        cap_d = pos_q;
      end
    end else begin
      deb_d = deb_dec;
      if (deb_dec == '0 && pressed) begin
        ready_d  = 1'b1;
        accepted = 1'b1;
      end
    end
    evt_o.accepted = accepted;
    evt_o.key      = accepted ? cap_q : '0;
    evt_o.held     = ready_d;
    evt_o.next_pos = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      deb_q   <= '0;
      cap_q   <= '0;
      ready_q <= 1'b0;
      rel_q   <= REL_RESET;
    end else if (en_i) begin
      pos_q   <= pos_d;
      deb_q   <= deb_d;
      cap_q   <= cap_d;
      ready_q <= ready_d;
      rel_q   <= rel_d;
    end
  end

endmodule

`default_nettype wire

[src/kpsw_clock.sv]
// Second prescaler, run flag and four-digit decimal seconds count.
// Depends on kpsw_pkg.
`default_nettype none

module kpsw_clock import kpsw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [PER_W-1:0] second_period_i,
  input  key_evt_t              evt_i,
  output logic                  event_o,
  output logic                  running_o,
  output logic [NDIGITS-1:0][DIGIT_W-1:0] digits_o
);

  logic [PER_W-1:0]                presc_q, presc_d;
  logic                            run_q, run_d;
  logic [NDIGITS-1:0][DIGIT_W-1:0] dig_q, dig_d;
  logic                            carry;
  logic                            evt;

  always_comb begin
    evt     = (presc_q == '0);
    presc_d = evt ? (second_period_i - PER_W'(1)) : (presc_q - PER_W'(1));
    dig_d   = dig_q;
    carry   = evt & run_q;
    for (int d = 0; d < NDIGITS; d++) begin
      if (carry) begin
        if (dig_q[d] >= DIGIT_MAX) begin
          dig_d[d] = '0;
        end else begin
          dig_d[d] = dig_q[d] + DIGIT_W'(1);
          carry    = 1'b0;
        end
      end
    end
    run_d = run_q;
    if (evt_i.accepted) begin
      case (evt_i.key)
        KEY_START: run_d = 1'b1;
        KEY_STOP:  run_d = 1'b0;
        KEY_CLEAR: begin
          run_d = 1'b0;
          dig_d = '0;
        end
        default: run_d = run_q;
      endcase
    end
    event_o   = evt;
    running_o = run_d;
    digits_o  = dig_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q <= '0;
      run_q   <= 1'b0;
      dig_q   <= '0;
    end else if (en_i) begin
      presc_q <= presc_d;
      run_q   <= run_d;
      dig_q   <= dig_d;
    end
  end

endmodule

`default_nettype wire

[src/keypad_stopwatch_controller_unit.sv]
// Keypad stopwatch controller, top level.
// Depends on kpsw_pkg, kpsw_if, kpsw_keypad and kpsw_clock.
//
// Usage:
//   in_i carries one timer tick per transfer: key_sense is the return-line
//   level at the current scan position (0 pressed). out_o carries one result
//   per tick: next scan position, key acceptance, held flag, run flag, second
//   event and the four seconds digits.
//   cfg_we_i/cfg_idx_i/cfg_data_i write debounce_ticks (0), release_ticks (1)
//   and second_period (2); other indexes are ignored. Write only while idle.
// Timing:
//   A tick is taken into an input register and processed when the output
//   register is empty or out_o is ready; its result lands in the output
//   register. One tick per cycle is sustained while out_o is ready; the
//   state update of the keypad and clock units is combinational logic.
// Reset:
//   Scan position, debounce count, run flag and digits clear; release count
//   loads 32; first tick gives a second event. Registers return to 32, 32, 997.
// Stall:
//   When out_o is not ready the result holds, the input register fills and
//   in_i deasserts ready; nothing is dropped.
`default_nettype none

module keypad_stopwatch_controller_unit import kpsw_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  kpsw_in_if.sink                    in_i,
  kpsw_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [DEB_W-1:0] deb_reg_q;
  logic [REL_W-1:0] rel_reg_q;
  logic [PER_W-1:0] per_reg_q;

  logic      s1_valid_q;
  logic      s1_sense_q;
  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic      adv;

  key_evt_t                        evt;
  logic                            sec_evt;
  logic                            running;
  logic [NDIGITS-1:0][DIGIT_W-1:0] digits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_reg_q <= DEB_RESET;
      rel_reg_q <= REL_RESET;
      per_reg_q <= PER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_DEBOUNCE: deb_reg_q <= cfg_data_i[DEB_W-1:0];
        CFG_RELEASE:  rel_reg_q <= cfg_data_i[REL_W-1:0];
        CFG_PERIOD:   per_reg_q <= cfg_data_i[PER_W-1:0];
        default:      deb_reg_q <= deb_reg_q;
      endcase
    end
  end

  assign adv         = s1_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready  = ~s1_valid_q | adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_sense_q <= in_i.data.key_sense;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  kpsw_keypad u_keypad (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (adv),
    .key_sense_i      (s1_sense_q),
    .debounce_ticks_i (deb_reg_q),
    .release_ticks_i  (rel_reg_q),
    .evt_o            (evt)
  );

  kpsw_clock u_clock (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (adv),
    .second_period_i (per_reg_q),
    .evt_i           (evt),
    .event_o         (sec_evt),
    .running_o       (running),
    .digits_o        (digits)
  );

  always_comb begin
    out_d.next_scan_position = evt.next_pos;
    out_d.key_accepted       = evt.accepted;
    out_d.accepted_key       = evt.key;
    out_d.key_held           = evt.held;
    out_d.running            = running;
    out_d.second_event       = sec_evt;
    out_d.digit_ones         = digits[0];
    out_d.digit_tens         = digits[1];
    out_d.digit_hundreds     = digits[2];
    out_d.digit_thousands    = digits[3];
  end

  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.key_accepted |-> out_q.key_held)
    else $error("accepted key not held");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.key_accepted && out_q.accepted_key == KEY_START
    |-> out_q.running)
    else $error("start key did not run the stopwatch");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.key_accepted && out_q.accepted_key == KEY_CLEAR
    |-> !out_q.running && out_q.digit_ones == '0 && out_q.digit_tens == '0
        && out_q.digit_hundreds == '0 && out_q.digit_thousands == '0)
    else $error("clear key left count");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.digit_ones <= DIGIT_MAX && out_q.digit_tens <= DIGIT_MAX
        && out_q.digit_hundreds <= DIGIT_MAX && out_q.digit_thousands <= DIGIT_MAX)
    else $error("digit out of decimal range");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q)
    else $error("pending tick lost");

endmodule

`default_nettype wire
